FILE: hdl/gif_lzw_code_packer_macros.svh
// Assertion macros used by the GIF LZW code packer top level.
// Depends on nothing; included by the files that carry checks.
`ifndef GIF_LZW_CODE_PACKER_MACROS_SVH
`define GIF_LZW_CODE_PACKER_MACROS_SVH

// Same-cycle implication check.
`define GLZW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glzw check failed");

// Next-cycle implication check.
`define GLZW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glzw check failed");

`endif

FILE: hdl/glzw_pkg.sv
// Types and constants of the GIF LZW code packer.
// No dependencies; used by the bit packer and the top level.
package glzw_pkg;

   localparam int CODE_W = 12;
   localparam int PIX_W = 8;
   localparam int KEY_W = CODE_W + PIX_W;
   localparam int PB_W = 4;
   localparam int ACC_W = 64;
   localparam int CNT_W = 7;
   localparam int WID_W = 4;

   localparam logic [PB_W-1:0] PB_RESET = 4'd8;
   localparam logic [PB_W-1:0] PB_MIN = 4'd1;
   localparam logic [PB_W-1:0] PB_MAX = 4'd8;
   localparam logic [PB_W-1:0] MIN_CODE_FLOOR = 4'd2;
   localparam logic [7:0] BLOCK_BYTES = 8'd255;
   localparam logic [2:0] MAX_BEATS = 3'd4;

   // One command per cycle to the bit packer.
   typedef struct packed {
      logic put;
      logic pad;
      logic pop;
      logic [CODE_W-1:0] value;
      logic [WID_W-1:0] width;
   } pack_cmd_type;

   // Packer status and the byte that a pop would take.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [7:0] byte_val;
      logic full;
      logic fin;
   } pack_stat_type;

endpackage

FILE: hdl/glzw_req_if.sv
// Channel interfaces of the GIF LZW code packer: pixel, byte and register write.
// Depends on nothing.
interface glzw_req_if;
   logic valid;
   logic ready;
   logic [7:0] pixel_index;
   logic last_pixel;
   modport source (output valid, output pixel_index, output last_pixel, input ready);
   modport sink (input valid, input pixel_index, input last_pixel, output ready);
endinterface

interface glzw_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic sub_block_full;
   logic stream_end;
   modport source (output valid, output data_byte, output sub_block_full,
                   output stream_end, input ready);
   modport sink (input valid, input data_byte, input sub_block_full,
                 input stream_end, output ready);
endinterface

interface glzw_csr_if;
   logic valid;
   logic ready;
   logic [3:0] palette_bits;
   modport source (output valid, output palette_bits, input ready);
   modport sink (input valid, input palette_bits, output ready);
endinterface

FILE: hdl/glzw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glzw_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, hold data between reads
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: hdl/glzw_bitpack.sv
// LSB-first bit packer: takes one put, pad or pop per cycle.
// Depends on glzw_pkg.
module glzw_bitpack (
   input  logic                   clock,
   input  logic                   reset,
   input  glzw_pkg::pack_cmd_type cmd,
   output glzw_pkg::pack_stat_type stat
);
   logic [glzw_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [glzw_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0] marks_ff, marks_in;
   logic [7:0] bpos_ff, bpos_in;
   logic [glzw_pkg::CODE_W-1:0] val_m;
   logic [7:0] sum_w;
   logic [7:0] cnt_pad;
   logic [3:0] nbytes;
   logic [7:0] bpos_inc;

   assign val_m = cmd.value & ~({glzw_pkg::CODE_W{1'b1}} << cmd.width);
   assign sum_w = 8'(cnt_ff) + 8'(cmd.width);
   assign cnt_pad = (8'(cnt_ff) + 8'd7) & 8'hF8;
   assign nbytes = cnt_pad[6:3];
   assign bpos_inc = bpos_ff + 8'd1;

   // Apply the command of this cycle
   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      marks_in = marks_ff;
      bpos_in = bpos_ff;
      if (cmd.put) begin
         if (sum_w <= 8'(glzw_pkg::ACC_W)) begin
            acc_in = acc_ff | ({{(glzw_pkg::ACC_W-glzw_pkg::CODE_W){1'b0}}, val_m} << cnt_ff);
            cnt_in = sum_w[glzw_pkg::CNT_W-1:0];
         end
      end else if (cmd.pad) begin
         cnt_in = cnt_pad[glzw_pkg::CNT_W-1:0];
         if (nbytes != 4'd0) begin
            marks_in = marks_ff | (8'd1 << (nbytes - 4'd1));
         end
      end else if (cmd.pop) begin
         acc_in = acc_ff >> 8;
         marks_in = marks_ff >> 1;
         cnt_in = cnt_ff - glzw_pkg::CNT_W'(8);
         bpos_in = (stat.full || stat.fin) ? 8'd0 : bpos_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
         marks_ff <= '0;
         bpos_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         marks_ff <= marks_in;
         bpos_ff <= bpos_in;
      end
   end

   assign stat.count = cnt_ff;
   assign stat.byte_val = acc_ff[7:0];
   assign stat.full = (bpos_inc >= glzw_pkg::BLOCK_BYTES);
   assign stat.fin = marks_ff[0];
endmodule

FILE: hdl/gif_lzw_code_packer.sv
// GIF LZW code packer: per pixel an accept, a hash head read, a compare per chain
// entry visited, a miss step (and a clear if full), flush, end code and pad
// on the last pixel, then up to 4 byte beats (held while the byte side stalls),
// then idle; an image's first pixel skips hashing. The chain walk sets the rate.
// Reset (synchronous, active high) empties the hash heads, clears the packer
// and sets palette_bits to 8; dictionary RAMs need no clearing.
module gif_lzw_code_packer #(
   parameter int DICT_ENTRIES = 4096,
   parameter int HASH_BUCKETS = 256
) (
   input  logic       clock,
   input  logic       reset,
   glzw_csr_if.sink   csr_chan,
   glzw_req_if.sink   req_chan,
   glzw_rsp_if.source rsp_chan
);
   `include "gif_lzw_code_packer_macros.svh"

   localparam int AW = $clog2(DICT_ENTRIES);
   localparam int HW = $clog2(HASH_BUCKETS);
   localparam logic [12:0] DICT_LIMIT = 13'(DICT_ENTRIES);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_HEAD  = 4'd1;
   localparam logic [3:0] S_CMP   = 4'd2;
   localparam logic [3:0] S_MISS  = 4'd3;
   localparam logic [3:0] S_CLR   = 4'd4;
   localparam logic [3:0] S_FLUSH = 4'd5;
   localparam logic [3:0] S_ENDC  = 4'd6;
   localparam logic [3:0] S_PAD   = 4'd7;
   localparam logic [3:0] S_DRAIN = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [3:0] pbits_ff, pbits_in;
   logic started_ff, started_in;
   logic [3:0] lat_min_ff, lat_min_in;
   logic [7:0] lat_mask_ff, lat_mask_in;
   logic [11:0] cur_ff, cur_in;
   logic [7:0] ch_ff, ch_in;
   logic last_ff, last_in;
   logic [HW-1:0] h_ff, h_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [12:0] next_ff, next_in;
   logic [3:0] width_ff, width_in;
   logic [12:0] bump_ff, bump_in;
   logic [HASH_BUCKETS-1:0] hvalid_ff, hvalid_in;
   logic [2:0] beats_ff, beats_in;
   logic rv_ff, rv_in;
   logic [7:0] rbyte_ff, rbyte_in;
   logic rfull_ff, rfull_in;
   logic rfin_ff, rfin_in;

   logic accept;
   logic [3:0] pb_cl, min_new, width_new;
   logic [7:0] mask_new, ch_acc;
   logic [11:0] clear_code;
   logic [12:0] hsum, bump_dbl;
   logic [AW-1:0] head_rd;
   logic [glzw_pkg::KEY_W-1:0] prefix_rd;
   logic [AW:0] link_rd;
   logic head_we, head_re, dict_we, dict_re;
   logic [AW-1:0] dict_raddr;
   glzw_pkg::pack_cmd_type pk_cmd;
   glzw_pkg::pack_stat_type pk_stat;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;

   // Clamp palette bits and derive the new image's code sizes
   always_comb begin
      pb_cl = pbits_ff;
      if (pbits_ff < glzw_pkg::PB_MIN) begin
         pb_cl = glzw_pkg::PB_MIN;
      end else if (pbits_ff > glzw_pkg::PB_MAX) begin
         pb_cl = glzw_pkg::PB_MAX;
      end
   end
   assign min_new = (pb_cl < glzw_pkg::MIN_CODE_FLOOR) ? glzw_pkg::MIN_CODE_FLOOR : pb_cl;
   assign width_new = min_new + 4'd1;
   assign mask_new = 8'((9'd1 << pb_cl) - 9'd1);
   assign ch_acc = req_chan.pixel_index & lat_mask_ff;
   assign clear_code = 12'd1 << lat_min_ff;
   assign hsum = {1'b0, cur_ff} + 13'(ch_acc);
   assign bump_dbl = bump_ff << 1;

   // Register write
   always_comb begin
      pbits_in = pbits_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         pbits_in = csr_chan.palette_bits;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      started_in = started_ff;
      lat_min_in = lat_min_ff;
      lat_mask_in = lat_mask_ff;
      cur_in = cur_ff;
      ch_in = ch_ff;
      last_in = last_ff;
      h_in = h_ff;
      pos_in = pos_ff;
      next_in = next_ff;
      width_in = width_ff;
      bump_in = bump_ff;
      hvalid_in = hvalid_ff;
      beats_in = beats_ff;
      rv_in = rv_ff && !rsp_chan.ready;
      rbyte_in = rbyte_ff;
      rfull_in = rfull_ff;
      rfin_in = rfin_ff;
      head_we = 1'b0;
      head_re = 1'b0;
      dict_we = 1'b0;
      dict_re = 1'b0;
      dict_raddr = pos_ff;
      pk_cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            head_re = accept;
            if (accept) begin
               last_in = req_chan.last_pixel;
               beats_in = 3'd0;
               if (!started_ff) begin
                  // Start an image: latch sizes, reset the table, queue a clear code
                  lat_min_in = min_new;
                  lat_mask_in = mask_new;
                  hvalid_in = '0;
                  width_in = width_new;
                  bump_in = 13'd1 << width_new;
                  next_in = (13'd1 << min_new) + 13'd2;
                  pk_cmd.put = 1'b1;
                  pk_cmd.value = 12'd1 << min_new;
                  pk_cmd.width = width_new;
                  cur_in = 12'(req_chan.pixel_index & mask_new);
                  started_in = 1'b1;
                  state_in = req_chan.last_pixel ? S_FLUSH : S_DRAIN;
               end else begin
                  ch_in = ch_acc;
                  h_in = hsum[HW-1:0];
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            if (hvalid_ff[h_ff]) begin
               dict_re = 1'b1;
               dict_raddr = head_rd;
               pos_in = head_rd;
               state_in = S_CMP;
            end else begin
               state_in = S_MISS;
            end
         end
         S_CMP: begin
            // Compare one chain entry, fetch the next
            if (prefix_rd == {cur_ff, ch_ff}) begin
               cur_in = 12'(pos_ff);
               state_in = last_ff ? S_FLUSH : S_DRAIN;
            end else if (link_rd[AW]) begin
               dict_re = 1'b1;
               dict_raddr = link_rd[AW-1:0];
               pos_in = link_rd[AW-1:0];
            end else begin
               state_in = S_MISS;
            end
         end
         S_MISS: begin
            pk_cmd.put = 1'b1;
            pk_cmd.value = cur_ff;
            pk_cmd.width = width_ff;
            if (next_ff < DICT_LIMIT) begin
               dict_we = 1'b1;
               head_we = 1'b1;
               hvalid_in[h_ff] = 1'b1;
               if (next_ff == bump_ff) begin
                  width_in = width_ff + 4'd1;
                  bump_in = (bump_dbl == DICT_LIMIT) ? bump_dbl + 13'd1 : bump_dbl;
               end
               next_in = next_ff + 13'd1;
               cur_in = 12'(ch_ff);
               state_in = last_ff ? S_FLUSH : S_DRAIN;
            end else begin
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            // Table full: send a clear code and start over
            pk_cmd.put = 1'b1;
            pk_cmd.value = clear_code;
            pk_cmd.width = width_ff;
            hvalid_in = '0;
            width_in = lat_min_ff + 4'd1;
            bump_in = 13'd1 << (lat_min_ff + 4'd1);
            next_in = 13'(clear_code) + 13'd2;
            cur_in = 12'(ch_ff);
            state_in = last_ff ? S_FLUSH : S_DRAIN;
         end
         S_FLUSH: begin
            pk_cmd.put = 1'b1;
            pk_cmd.value = cur_ff;
            pk_cmd.width = width_ff;
            state_in = S_ENDC;
         end
         S_ENDC: begin
            pk_cmd.put = 1'b1;
            pk_cmd.value = clear_code + 12'd1;
            pk_cmd.width = width_ff;
            state_in = S_PAD;
         end
         S_PAD: begin
            pk_cmd.pad = 1'b1;
            started_in = 1'b0;
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // Hand out up to four whole bytes for this pixel
            if (beats_ff < glzw_pkg::MAX_BEATS && pk_stat.count >= 7'd8) begin
               if (!rv_ff || rsp_chan.ready) begin
                  pk_cmd.pop = 1'b1;
                  rv_in = 1'b1;
                  rbyte_in = pk_stat.byte_val;
                  rfull_in = pk_stat.full;
                  rfin_in = pk_stat.fin;
                  beats_in = beats_ff + 3'd1;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pbits_ff <= glzw_pkg::PB_RESET;
         started_ff <= 1'b0;
         lat_min_ff <= glzw_pkg::PB_MAX;
         lat_mask_ff <= 8'hFF;
         cur_ff <= '0;
         next_ff <= 13'd258;
         width_ff <= 4'd9;
         bump_ff <= 13'd512;
         hvalid_ff <= '0;
         beats_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pbits_ff <= pbits_in;
         started_ff <= started_in;
         lat_min_ff <= lat_min_in;
         lat_mask_ff <= lat_mask_in;
         cur_ff <= cur_in;
         next_ff <= next_in;
         width_ff <= width_in;
         bump_ff <= bump_in;
         hvalid_ff <= hvalid_in;
         beats_ff <= beats_in;
         rv_ff <= rv_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      last_ff <= last_in;
      h_ff <= h_in;
      pos_ff <= pos_in;
      rbyte_ff <= rbyte_in;
      rfull_ff <= rfull_in;
      rfin_ff <= rfin_in;
   end

   assign rsp_chan.valid = rv_ff;
   assign rsp_chan.data_byte = rbyte_ff;
   assign rsp_chan.sub_block_full = rfull_ff;
   assign rsp_chan.stream_end = rfin_ff;

   glzw_ram #(.WIDTH(AW), .DEPTH(HASH_BUCKETS)) u_heads (
      .clock (clock),
      .we    (head_we),
      .waddr (h_ff),
      .wdata (next_ff[AW-1:0]),
      .re    (head_re),
      .raddr (hsum[HW-1:0]),
      .rdata (head_rd)
   );

   glzw_ram #(.WIDTH(glzw_pkg::KEY_W), .DEPTH(DICT_ENTRIES)) u_prefix (
      .clock (clock),
      .we    (dict_we),
      .waddr (next_ff[AW-1:0]),
      .wdata ({cur_ff, ch_ff}),
      .re    (dict_re),
      .raddr (dict_raddr),
      .rdata (prefix_rd)
   );

   glzw_ram #(.WIDTH(AW + 1), .DEPTH(DICT_ENTRIES)) u_link (
      .clock (clock),
      .we    (dict_we),
      .waddr (next_ff[AW-1:0]),
      .wdata ({hvalid_ff[h_ff], head_rd}),
      .re    (dict_re),
      .raddr (dict_raddr),
      .rdata (link_rd)
   );

   glzw_bitpack u_pack (
      .clock (clock),
      .reset (reset),
      .cmd   (pk_cmd),
      .stat  (pk_stat)
   );

   `GLZW_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != S_IDLE)
   `GLZW_ASSERT_NOW(a_pop_whole_byte, clock, reset, pk_cmd.pop, pk_stat.count >= 7'd8)
   `GLZW_ASSERT_NOW(a_write_in_range, clock, reset, dict_we, next_ff < DICT_LIMIT)
   `GLZW_ASSERT_NOW(a_end_only_at_pad, clock, reset, $fell(started_ff), $past(state_ff) == S_PAD)
endmodule
